// ===== rtl/mts_pkg.sv =====
// mts_pkg: shared types and constants for the melody tone sequencer
// command codes, register indexes, reset values, sequencer states
// no dependencies
package mts_pkg;

    localparam int SONG_DEPTH_DEFAULT = 256;

    // command codes carried by a request
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK_HZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SONG_TEMPO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO_OVERRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT   = 3'd5;

    // register reset values
    localparam logic [31:0] RST_TIMER_CLOCK_HZ = 32'd72000000;
    localparam logic [15:0] RST_PWM_PERIOD     = 16'd100;
    localparam logic [15:0] RST_SONG_TEMPO     = 16'd2000;
    localparam logic [15:0] RST_TEMPO_OVERRIDE = 16'd0;
    localparam logic [8:0]  RST_SONG_LENGTH    = 9'd1;
    localparam logic [7:0]  RST_REPEAT_COUNT   = 8'd1;

    // shared divider
    localparam int DIV_W = 32;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_PRESCALE = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_DURATION = 6'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL_CHECK,
        ST_PRE_DIV,
        ST_DUR_LOAD,
        ST_DUR_DIV,
        ST_DUR_FIN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/melody_tone_sequencer_top.sv =====
// melody_tone_sequencer_top: melody table, playback sequencer and shared divider
// depends on mts_pkg (types, constants)
//
// Plays a stored melody as PWM tone settings. Every request gives exactly one
// response carrying playback status, tone enable, prescaler, current note
// frequency and next entry index. Write, start, stop and tick requests that
// do not play a table entry go straight from acceptance to the response
// state. A tick that plays an entry passes through the registered table read
// and the 16x16 period-by-frequency multiply; then a single restoring divider
// producing one quotient bit per cycle runs 32 steps for the prescaler
// (clock / (period * freq)) and 16 steps for the note duration (tempo /
// length code), followed by the dotted scaling and deadline add. A rest
// entry, or a zero period * freq product, skips the prescaler division.
// Requests are taken only while the sequencer is idle; a finished response
// waits in its own output register, so the next request can be taken before
// it is read. Configuration writes are always accepted and must be issued
// while no request is in progress. The melody table is a SONG_DEPTH-entry
// memory with no clearing pass; entries not yet written read as undefined.

module melody_tone_sequencer_top #(
    parameter int SONG_DEPTH = mts_pkg::SONG_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,

    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_cmd,
    input  logic [31:0]                    s_now_time,
    input  logic [7:0]                     s_entry_index,
    input  logic [15:0]                    s_entry_freq,
    input  logic signed [7:0]              s_entry_length_code,

    // response channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_playing,
    output logic                           m_tone_enable,
    output logic [31:0]                    m_prescaler,
    output logic [15:0]                    m_note_freq,
    output logic [8:0]                     m_note_index
);

    // table address width, entry counter width, compare widths
    localparam int AW = $clog2(SONG_DEPTH);
    localparam int NW = $clog2(SONG_DEPTH + 1);
    localparam int CW = (NW > 9) ? NW : 9;
    localparam int IW = ((AW + 1) > 8) ? (AW + 1) : 8;
    localparam logic [CW-1:0] DEPTH_C = CW'(SONG_DEPTH);
    localparam logic [IW-1:0] DEPTH_I = IW'(SONG_DEPTH);

    // configuration registers
    logic [31:0] timer_clock_hz_reg;
    logic [15:0] pwm_period_reg;
    logic [15:0] song_tempo_reg;
    logic [15:0] tempo_override_reg;
    logic [8:0]  song_length_reg;
    logic [7:0]  repeat_count_reg;

    // playback state
    mts_pkg::state_t state_reg, state_next;
    logic [NW-1:0] next_entry_reg;
    logic [7:0]    repeats_left_reg;
    logic [31:0]   deadline_reg;
    logic          active_reg;
    logic [31:0]   prescaler_reg;
    logic          output_on_reg;
    logic [15:0]   current_freq_reg;

    // per-note working registers
    logic [31:0]   now_reg;
    logic [7:0]    code_reg;
    logic [31:0]   mul_reg;

    // melody table, frequency in the upper 16 bits, length code in the lower 8
    logic [23:0]   table_mem [SONG_DEPTH];
    logic [23:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [IW-1:0] wr_index_ext;

    // shared restoring divider
    logic [31:0]                   div_rem_reg;
    logic [31:0]                   div_quo_reg;
    logic [31:0]                   div_den_reg;
    logic [mts_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [32:0]                   div_shift;
    logic [33:0]                   div_diff;
    logic                          div_ge;
    logic [31:0]                   div_rem_next;
    logic [31:0]                   div_quo_next;
    logic                          div_last;

    // response register
    logic        m_valid_reg;
    logic        m_playing_reg;
    logic        m_tone_enable_reg;
    logic [31:0] m_prescaler_reg;
    logic [15:0] m_note_freq_reg;
    logic [8:0]  m_note_index_reg;

    // request decode
    logic          s_fire;
    logic          out_free;
    logic [CW-1:0] song_len;
    logic [CW-1:0] next_entry_ext;
    logic          tick_due;
    logic          song_end;
    logic [15:0]   tempo_eff;
    logic          code_neg;
    logic [7:0]    code_mag;
    logic [16:0]   dur_triple;
    logic [16:0]   duration;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == mts_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // effective song length, capped at the table depth
    assign song_len = (CW'(song_length_reg) > DEPTH_C) ? DEPTH_C : CW'(song_length_reg);
    assign next_entry_ext = CW'(next_entry_reg);
    assign tick_due = active_reg && (s_now_time >= deadline_reg);
    assign song_end = (next_entry_ext >= song_len);

    // duration operands
    assign tempo_eff = (tempo_override_reg != 16'd0) ? tempo_override_reg : song_tempo_reg;
    assign code_neg  = code_reg[7];
    always_comb begin
        if (code_neg) begin
            code_mag = 8'(~code_reg + 8'd1);
        end else if (code_reg == 8'd0) begin
            code_mag = 8'd1;
        end else begin
            code_mag = code_reg;
        end
    end
    // dotted note: quotient * 3 / 2
    assign dur_triple = 17'(({2'b00, div_quo_reg[15:0]} + {1'b0, div_quo_reg[15:0], 1'b0}) >> 1);
    assign duration   = code_neg ? dur_triple : {1'b0, div_quo_reg[15:0]};

    // one divider step
    assign div_shift    = {div_rem_reg, div_quo_reg[31]};
    assign div_diff     = {1'b0, div_shift} - {2'b00, div_den_reg};
    assign div_ge       = !div_diff[33];
    assign div_rem_next = div_ge ? div_diff[31:0] : div_shift[31:0];
    assign div_quo_next = {div_quo_reg[30:0], div_ge};
    assign div_last     = (div_cnt_reg == mts_pkg::DIV_CNT_W'(1));

    // table write decode, out-of-range indexes dropped
    assign wr_index_ext = IW'(s_entry_index);
    assign wr_addr      = wr_index_ext[AW-1:0];
    assign wr_en        = s_fire && (s_cmd == mts_pkg::CMD_WRITE) && (wr_index_ext < DEPTH_I);

    // melody table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= {s_entry_freq, s_entry_length_code};
        end
        rd_data_reg <= table_mem[next_entry_reg[AW-1:0]];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_clock_hz_reg <= mts_pkg::RST_TIMER_CLOCK_HZ;
            pwm_period_reg     <= mts_pkg::RST_PWM_PERIOD;
            song_tempo_reg     <= mts_pkg::RST_SONG_TEMPO;
            tempo_override_reg <= mts_pkg::RST_TEMPO_OVERRIDE;
            song_length_reg    <= mts_pkg::RST_SONG_LENGTH;
            repeat_count_reg   <= mts_pkg::RST_REPEAT_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mts_pkg::REG_TIMER_CLOCK_HZ: timer_clock_hz_reg <= cfg_data;
                mts_pkg::REG_PWM_PERIOD:     pwm_period_reg     <= cfg_data[15:0];
                mts_pkg::REG_SONG_TEMPO:     song_tempo_reg     <= cfg_data[15:0];
                mts_pkg::REG_TEMPO_OVERRIDE: tempo_override_reg <= cfg_data[15:0];
                mts_pkg::REG_SONG_LENGTH:    song_length_reg    <= cfg_data[8:0];
                mts_pkg::REG_REPEAT_COUNT:   repeat_count_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if ((s_cmd == mts_pkg::CMD_TICK) && tick_due && !song_end) begin
                        state_next = mts_pkg::ST_FETCH;
                    end else begin
                        state_next = mts_pkg::ST_DONE;
                    end
                end
            end
            mts_pkg::ST_FETCH: begin
                // a rest skips the prescaler
                if (rd_data_reg[23:8] == 16'd0) begin
                    state_next = mts_pkg::ST_DUR_LOAD;
                end else begin
                    state_next = mts_pkg::ST_MUL_CHECK;
                end
            end
            mts_pkg::ST_MUL_CHECK: begin
                if (mul_reg == 32'd0) begin
                    state_next = mts_pkg::ST_DUR_LOAD;
                end else begin
                    state_next = mts_pkg::ST_PRE_DIV;
                end
            end
            mts_pkg::ST_PRE_DIV: begin
                if (div_last) begin
                    state_next = mts_pkg::ST_DUR_LOAD;
                end
            end
            mts_pkg::ST_DUR_LOAD: begin
                state_next = mts_pkg::ST_DUR_DIV;
            end
            mts_pkg::ST_DUR_DIV: begin
                if (div_last) begin
                    state_next = mts_pkg::ST_DUR_FIN;
                end
            end
            mts_pkg::ST_DUR_FIN: begin
                state_next = mts_pkg::ST_DONE;
            end
            mts_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = mts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase
    end

    // playback state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_entry_reg   <= '0;
            repeats_left_reg <= '0;
            deadline_reg     <= '0;
            active_reg       <= 1'b0;
            prescaler_reg    <= '0;
            output_on_reg    <= 1'b0;
            current_freq_reg <= '0;
        end else begin
            case (state_reg)
                mts_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        case (s_cmd)
                            mts_pkg::CMD_TICK: begin
                                // song end: repeat handling, deadline kept
                                if (tick_due && song_end) begin
                                    if (repeats_left_reg == 8'd0) begin
                                        next_entry_reg <= '0;
                                    end else if (repeats_left_reg == 8'd1) begin
                                        repeats_left_reg <= 8'd0;
                                        active_reg       <= 1'b0;
                                        next_entry_reg   <= '0;
                                        output_on_reg    <= 1'b0;
                                        current_freq_reg <= '0;
                                    end else begin
                                        repeats_left_reg <= repeats_left_reg - 8'd1;
                                        next_entry_reg   <= '0;
                                    end
                                end
                            end
                            mts_pkg::CMD_START: begin
                                active_reg       <= 1'b1;
                                next_entry_reg   <= '0;
                                deadline_reg     <= '0;
                                repeats_left_reg <= repeat_count_reg;
                                output_on_reg    <= 1'b0;
                                current_freq_reg <= '0;
                            end
                            mts_pkg::CMD_STOP: begin
                                active_reg       <= 1'b0;
                                next_entry_reg   <= '0;
                                output_on_reg    <= 1'b0;
                                current_freq_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                mts_pkg::ST_FETCH: begin
                    current_freq_reg <= rd_data_reg[23:8];
                    output_on_reg    <= (rd_data_reg[23:8] != 16'd0);
                end
                mts_pkg::ST_MUL_CHECK: begin
                    // zero divisor saturates
                    if (mul_reg == 32'd0) begin
                        prescaler_reg <= 32'hFFFF_FFFF;
                    end
                end
                mts_pkg::ST_PRE_DIV: begin
                    if (div_last) begin
                        prescaler_reg <= div_quo_next;
                    end
                end
                mts_pkg::ST_DUR_FIN: begin
                    deadline_reg   <= now_reg + 32'(duration);
                    next_entry_reg <= next_entry_reg + NW'(1);
                end
                default: ;
            endcase
        end
    end

    // per-note working registers and the shared divider
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            now_reg <= s_now_time;
        end
        case (state_reg)
            mts_pkg::ST_FETCH: begin
                code_reg <= rd_data_reg[7:0];
                mul_reg  <= pwm_period_reg * rd_data_reg[23:8];
            end
            mts_pkg::ST_MUL_CHECK: begin
                div_rem_reg <= '0;
                div_quo_reg <= timer_clock_hz_reg;
                div_den_reg <= mul_reg;
                div_cnt_reg <= mts_pkg::DIV_STEPS_PRESCALE;
            end
            mts_pkg::ST_DUR_LOAD: begin
                // tempo in the upper half so 16 steps suffice
                div_rem_reg <= '0;
                div_quo_reg <= {tempo_eff, 16'd0};
                div_den_reg <= {24'd0, code_mag};
                div_cnt_reg <= mts_pkg::DIV_STEPS_DURATION;
            end
            mts_pkg::ST_PRE_DIV, mts_pkg::ST_DUR_DIV: begin
                div_rem_reg <= div_rem_next;
                div_quo_reg <= div_quo_next;
                div_cnt_reg <= div_cnt_reg - mts_pkg::DIV_CNT_W'(1);
            end
            default: ;
        endcase
    end

    // response register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == mts_pkg::ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == mts_pkg::ST_DONE) && out_free) begin
            m_playing_reg     <= active_reg;
            m_tone_enable_reg <= output_on_reg;
            m_prescaler_reg   <= prescaler_reg;
            m_note_freq_reg   <= active_reg ? current_freq_reg : 16'd0;
            m_note_index_reg  <= next_entry_ext[8:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_playing     = m_playing_reg;
    assign m_tone_enable = m_tone_enable_reg;
    assign m_prescaler   = m_prescaler_reg;
    assign m_note_freq   = m_note_freq_reg;
    assign m_note_index  = m_note_index_reg;

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for melody_tone_sequencer_top
// holds its own model of the melody table and playback sequencer and checks every response
// depends on mts_pkg and the rtl top level
module tb_top;

    // ------------------------------------------------------------------
    // bench constants
    // ------------------------------------------------------------------
    localparam int TABLE_DEPTH    = mts_pkg::SONG_DEPTH_DEFAULT;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 4;      // settling margin after the last response is in
    localparam int DRAIN_CYCLES   = 80;     // final wait for stray responses
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles before giving up
    localparam int MAX_PRINTED    = 100;

    // register indexes beyond the defined six, which must do nothing
    localparam logic [mts_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [mts_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // one response as seen on the m_ channel
    typedef struct packed {
        logic        playing;
        logic        tone_on;
        logic [31:0] prescaler;
        logic [15:0] freq;
        logic [8:0]  index;
    } play_status_t;

    // ------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------
    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [31:0]                    cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [1:0]                     s_cmd;
    logic [31:0]                    s_now_time;
    logic [7:0]                     s_entry_index;
    logic [15:0]                    s_entry_freq;
    logic signed [7:0]              s_entry_length_code;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_playing;
    logic                           m_tone_enable;
    logic [31:0]                    m_prescaler;
    logic [15:0]                    m_note_freq;
    logic [8:0]                     m_note_index;

    // ------------------------------------------------------------------
    // sequencer model: register copies, melody table and playback state
    // ------------------------------------------------------------------
    logic [31:0] reg_clock_hz = mts_pkg::RST_TIMER_CLOCK_HZ;
    logic [15:0] reg_period   = mts_pkg::RST_PWM_PERIOD;
    logic [15:0] reg_tempo    = mts_pkg::RST_SONG_TEMPO;
    logic [15:0] reg_override = mts_pkg::RST_TEMPO_OVERRIDE;
    logic [8:0]  reg_song_len = mts_pkg::RST_SONG_LENGTH;
    logic [7:0]  reg_repeats  = mts_pkg::RST_REPEAT_COUNT;

    logic [15:0] tone_freq_tbl [TABLE_DEPTH];
    logic [7:0]  tone_code_tbl [TABLE_DEPTH];
    bit          tone_written  [TABLE_DEPTH];   // entries the bench has loaded so far

    logic [8:0]  seq_next      = '0;
    logic [7:0]  seq_repeats   = '0;
    logic [31:0] seq_deadline  = '0;
    logic        seq_active    = 1'b0;
    logic        seq_tone_on   = 1'b0;
    logic [31:0] seq_prescaler = '0;
    logic [15:0] seq_freq      = '0;

    // responses the model says are still to come, oldest first
    play_status_t predicted_status_q [$];

    // run bookkeeping
    int  request_count  = 0;
    int  response_count = 0;
    int  mismatch_count = 0;
    int  notes_played   = 0;
    int  song_ends      = 0;
    int  reg_phases     = 0;
    int  quiet_cycles   = 0;

    // idling and hold-off control shared by the driving processes
    bit  no_idle     = 1'b0;
    bit  hold_go     = 1'b0;
    bit  hold_active = 1'b0;

    // ------------------------------------------------------------------
    // device under test
    // ------------------------------------------------------------------
    melody_tone_sequencer_top #(
        .SONG_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_now_time          (s_now_time),
        .s_entry_index       (s_entry_index),
        .s_entry_freq        (s_entry_freq),
        .s_entry_length_code (s_entry_length_code),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_playing           (m_playing),
        .m_tone_enable       (m_tone_enable),
        .m_prescaler         (m_prescaler),
        .m_note_freq         (m_note_freq),
        .m_note_index        (m_note_index)
    );

    // clock, period 8
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // model functions
    // ------------------------------------------------------------------

    // entries actually in play: lengths beyond the table are clipped to it
    function automatic logic [8:0] song_span();
        return (reg_song_len > TABLE_DEPTH) ? 9'(TABLE_DEPTH) : reg_song_len;
    endfunction

    // note length in ticks from the stored length code
    function automatic logic [31:0] note_ticks(logic [7:0] code);
        logic [31:0] whole;
        logic [31:0] mag;
        whole = (reg_override != 16'd0) ? 32'(reg_override) : 32'(reg_tempo);
        if (code == 8'd0)
            return whole;               // zero code behaves as a whole note
        if (!code[7])
            return whole / 32'(code);
        // dotted note: magnitude of the negative code, then one and a half
        mag = 32'd256 - 32'(code);
        return ((whole / mag) * 32'd3) / 32'd2;
    endfunction

    function automatic void halt_playback();
        seq_active  = 1'b0;
        seq_next    = '0;
        seq_tone_on = 1'b0;
        seq_freq    = '0;
    endfunction

    // advances the model by one request and gives the response it causes
    function automatic play_status_t sequencer_step(mts_pkg::cmd_t c, logic [31:0] t,
                                                    logic [7:0] ix, logic [15:0] f,
                                                    logic [7:0] lc);
        play_status_t st;
        logic [7:0]   slot;
        logic [31:0]  product;
        case (c)
            mts_pkg::CMD_TICK: begin
                if (seq_active && t >= seq_deadline) begin
                    if (seq_next >= song_span()) begin
                        // song end: deadline untouched, repeat count decides
                        song_ends++;
                        if (seq_repeats == 8'd0) begin
                            seq_next = '0;
                        end else begin
                            seq_repeats = seq_repeats - 8'd1;
                            if (seq_repeats == 8'd0)
                                halt_playback();
                            else
                                seq_next = '0;
                        end
                    end else begin
                        slot     = seq_next[7:0];
                        seq_freq = tone_freq_tbl[slot];
                        if (seq_freq == 16'd0) begin
                            seq_tone_on = 1'b0;     // rest keeps the old prescaler
                        end else begin
                            seq_tone_on   = 1'b1;
                            product       = 32'(reg_period) * 32'(seq_freq);
                            seq_prescaler = (product == 32'd0) ? '1 : reg_clock_hz / product;
                        end
                        seq_deadline = t + note_ticks(tone_code_tbl[slot]);
                        seq_next     = seq_next + 9'd1;
                        notes_played++;
                    end
                end
            end
            mts_pkg::CMD_WRITE: begin
                tone_freq_tbl[ix] = f;
                tone_code_tbl[ix] = lc;
                tone_written[ix]  = 1'b1;
            end
            mts_pkg::CMD_START: begin
                halt_playback();
                seq_deadline = '0;
                seq_repeats  = reg_repeats;
                seq_active   = 1'b1;
            end
            default: begin
                halt_playback();
            end
        endcase
        st.playing   = seq_active;
        st.tone_on   = seq_tone_on;
        st.prescaler = seq_prescaler;
        st.freq      = seq_active ? seq_freq : 16'd0;
        st.index     = seq_next;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // random field helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_freq();
        case ($urandom_range(0, 9))
            0:       return 16'd0;                          // rest
            1, 2:    return 16'($urandom);
            default: return 16'($urandom_range(20, 5000));
        endcase
    endfunction

    function automatic logic [7:0] rand_code();
        int code;
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1, 2:    return 8'($urandom);
            default: begin
                code = $urandom_range(1, 16);
                if ($urandom_range(0, 1) == 1)
                    code = -code;                           // dotted
                return 8'(code);
            end
        endcase
    endfunction

    // a tick time at or shortly after the deadline, clipped at the top of the range
    function automatic logic [31:0] due_now();
        logic [31:0] slack;
        slack = ~seq_deadline;
        return seq_deadline + ((slack < 32'd40) ? $urandom_range(0, slack) : $urandom_range(0, 40));
    endfunction

    // mostly due ticks, some early ones and some anywhere in the range
    function automatic logic [31:0] pick_tick_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75 || seq_deadline == 32'd0)
            return due_now();
        if (roll < 90)
            return seq_deadline - $urandom_range(1, (seq_deadline < 32'd100) ? seq_deadline : 100);
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // error reporting
    // ------------------------------------------------------------------
    task automatic report_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] error: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------

    // offers one request from the falling edge, with random idle cycles first,
    // and folds it into the model at the edge where it is taken
    task automatic send_req(mts_pkg::cmd_t c, logic [31:0] t, logic [7:0] ix,
                            logic [15:0] f, logic [7:0] lc);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_cmd               <= c;
        s_now_time          <= t;
        s_entry_index       <= ix;
        s_entry_freq        <= f;
        s_entry_length_code <= lc;
        do
            @(posedge aclk);
        while (!s_ready);
        request_count++;
        predicted_status_q.push_back(sequencer_step(c, t, ix, f, lc));
    endtask

    // request with the unused fields filled at random
    task automatic send_cmd(mts_pkg::cmd_t c);
        send_req(c, $urandom, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // tick request; an entry never loaded is written first so it is never played blank
    task automatic send_tick(logic [31:0] t);
        if (seq_active && t >= seq_deadline && seq_next < song_span()
                && !tone_written[seq_next[7:0]])
            send_req(mts_pkg::CMD_WRITE, $urandom, seq_next[7:0], rand_freq(), rand_code());
        send_req(mts_pkg::CMD_TICK, t, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // drops valid and waits until every response is in and the block is quiet
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predicted_status_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [mts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            mts_pkg::REG_TIMER_CLOCK_HZ: reg_clock_hz = data;
            mts_pkg::REG_PWM_PERIOD:     reg_period   = data[15:0];
            mts_pkg::REG_SONG_TEMPO:     reg_tempo    = data[15:0];
            mts_pkg::REG_TEMPO_OVERRIDE: reg_override = data[15:0];
            mts_pkg::REG_SONG_LENGTH:    reg_song_len = data[8:0];
            mts_pkg::REG_REPEAT_COUNT:   reg_repeats  = data[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // writes all six registers once the block has gone quiet
    task automatic set_regs(logic [31:0] clk_hz, logic [15:0] period, logic [15:0] tempo,
                            logic [15:0] ovr, logic [8:0] len, logic [7:0] reps);
        wait_idle();
        write_reg(mts_pkg::REG_TIMER_CLOCK_HZ, clk_hz);
        write_reg(mts_pkg::REG_PWM_PERIOD,     32'(period));
        write_reg(mts_pkg::REG_SONG_TEMPO,     32'(tempo));
        write_reg(mts_pkg::REG_TEMPO_OVERRIDE, 32'(ovr));
        write_reg(mts_pkg::REG_SONG_LENGTH,    32'(len));
        write_reg(mts_pkg::REG_REPEAT_COUNT,   32'(reps));
        reg_phases++;
    endtask

    // one well-formed playback: start, then mostly ticks with the odd edit,
    // restart or stop mixed in
    task automatic play_song(int n_ticks);
        int k;
        int roll;
        send_cmd(mts_pkg::CMD_START);
        for (k = 0; k < n_ticks; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                send_req(mts_pkg::CMD_WRITE, $urandom,
                         (song_span() > 0) ? 8'($urandom_range(0, song_span() - 1))
                                           : 8'($urandom),
                         rand_freq(), rand_code());
            else if (roll < 10)
                send_cmd(mts_pkg::CMD_STOP);
            else if (roll < 12)
                send_cmd(mts_pkg::CMD_START);
            else
                send_tick(pick_tick_time());
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked requests at reset register values and a short five-note song
    task automatic test_directed_cases();
        send_tick(32'd0);                                       // tick while idle
        send_req(mts_pkg::CMD_WRITE, 32'd0, 8'd0, 16'd440, 8'd4);
        send_req(mts_pkg::CMD_WRITE, '1, 8'd255, 16'hFFFF, 8'h80); // last slot, most negative
        send_cmd(mts_pkg::CMD_START);
        send_tick(32'd0);                                       // first note sounds
        send_tick(seq_deadline - 32'd1);                        // one short of the deadline
        send_tick(seq_deadline);                                // song end, single play used up
        send_tick('1);                                          // idle again
        send_req(mts_pkg::CMD_WRITE, '1, 8'd1, 16'd0, 8'd0);    // rest with zero code
        send_req(mts_pkg::CMD_WRITE, '0, 8'd2, 16'd1, 8'd127);
        send_req(mts_pkg::CMD_WRITE, '1, 8'd3, 16'hFFFF, 8'hFF); // dotted, code minus one
        send_req(mts_pkg::CMD_WRITE, '0, 8'd4, 16'd1000, 8'h80);
        set_regs(mts_pkg::RST_TIMER_CLOCK_HZ, mts_pkg::RST_PWM_PERIOD, mts_pkg::RST_SONG_TEMPO,
                 mts_pkg::RST_TEMPO_OVERRIDE, 9'd5, 8'd2);
        send_cmd(mts_pkg::CMD_START);
        repeat (5) send_tick(seq_deadline);
        send_tick(seq_deadline);                                // end of first pass, loops
        send_tick(32'hFFFF_FFF0);                               // deadline wraps past zero
        send_cmd(mts_pkg::CMD_START);                           // restart while playing
        send_tick(32'd0);
        send_cmd(mts_pkg::CMD_STOP);
    endtask

    // every register at the ends of its range
    task automatic test_register_extremes();
        // widest clock, unit period, slowest tempo: whole table played once
        set_regs('1, 16'd1, 16'hFFFF, 16'd0, 9'd256, 8'd1);
        send_cmd(mts_pkg::CMD_START);
        repeat (258) send_tick(due_now());
        // empty song looping forever
        set_regs(32'd1000000, 16'd50, 16'd500, 16'd0, 9'd0, 8'd0);
        send_cmd(mts_pkg::CMD_START);
        repeat (4) send_tick(due_now());
        // zero period saturates the prescaler, zero tempo gives zero-length notes
        set_regs(32'd0, 16'd0, 16'd0, 16'd0, 9'd3, 8'd255);
        send_cmd(mts_pkg::CMD_START);
        repeat (12) send_tick(due_now());
        // widest period and override, song length past the table
        set_regs('1, 16'hFFFF, 16'd1, 16'hFFFF, 9'h1FF, 8'd2);
        send_cmd(mts_pkg::CMD_START);
        repeat (20) send_tick(due_now());
        // two plays of a two-note song, stopping by itself
        set_regs(32'd72000000, 16'd1, 16'd3, 16'd1, 9'd2, 8'd2);
        send_cmd(mts_pkg::CMD_START);
        repeat (8) send_tick(due_now());
        // writes to the spare indexes change nothing
        wait_idle();
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        send_tick(due_now());
    endtask

    // random register settings, each followed by a random song
    task automatic test_random_songs();
        logic [31:0] clk_hz;
        logic [15:0] period;
        logic [15:0] tempo;
        logic [15:0] ovr;
        logic [8:0]  len;
        logic [7:0]  reps;
        int          phase;
        for (phase = 0; phase < 11; phase++) begin
            clk_hz = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(1000000, 200000000);
            if ($urandom_range(0, 19) == 0)
                period = 16'd0;
            else if ($urandom_range(0, 1) == 1)
                period = 16'($urandom_range(1, 1000));
            else
                period = 16'($urandom_range(1, 65535));
            tempo = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            ovr   = ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom);
            case ($urandom_range(0, 9))
                0:       len = 9'd0;
                1:       len = 9'($urandom_range(13, 64));
                2:       len = 9'($urandom_range(257, 511));
                default: len = 9'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: reps = 8'd0;
                3, 4:    reps = 8'($urandom);
                default: reps = 8'($urandom_range(1, 4));
            endcase
            // a long stretch in the middle with neither side idling
            no_idle = (phase >= 4 && phase <= 6);
            set_regs(clk_hz, period, tempo, ovr, len, reps);
            play_song($urandom_range(40, 70));
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        set_regs(32'd48000000, 16'd250, 16'd1600, 16'd0, 9'd8, 8'd0);
        no_idle = 1'b1;
        send_cmd(mts_pkg::CMD_START);
        hold_go = 1'b1;
        repeat (30) send_tick(due_now());
        no_idle = 1'b0;
    endtask

    // unshaped requests: any command, any field values
    task automatic test_random_noise();
        mts_pkg::cmd_t c;
        int            k;
        for (k = 0; k < 100; k++) begin
            c = mts_pkg::cmd_t'($urandom_range(0, 3));
            if (c == mts_pkg::CMD_TICK)
                send_tick($urandom);
            else
                send_cmd(c);
        end
    endtask

    // ------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------

    // ready toggles at random unless held off or in the no-idle stretch
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_active)
                m_ready <= 1'b0;
            else if (no_idle)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // hold-off timing, counted here so the sender carries on regardless
    initial begin
        forever begin
            wait (hold_go);
            hold_go     = 1'b0;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active = 1'b0;
        end
    end

    // every accepted response against the oldest prediction, field by field
    always @(posedge aclk) begin
        play_status_t want;
        if (aresetn && m_valid && m_ready) begin
            response_count++;
            if (predicted_status_q.size() == 0) begin
                report_error($sformatf("response %0d arrived with no request outstanding",
                                       response_count));
            end else begin
                want = predicted_status_q.pop_front();
                if (m_playing !== want.playing)
                    report_error($sformatf("response %0d playing: got %0h, expected %0h",
                                           response_count, m_playing, want.playing));
                if (m_tone_enable !== want.tone_on)
                    report_error($sformatf("response %0d tone_enable: got %0h, expected %0h",
                                           response_count, m_tone_enable, want.tone_on));
                if (m_prescaler !== want.prescaler)
                    report_error($sformatf("response %0d prescaler: got %0h, expected %0h",
                                           response_count, m_prescaler, want.prescaler));
                if (m_note_freq !== want.freq)
                    report_error($sformatf("response %0d note_freq: got %0h, expected %0h",
                                           response_count, m_note_freq, want.freq));
                if (m_note_index !== want.index)
                    report_error($sformatf("response %0d note_index: got %0h, expected %0h",
                                           response_count, m_note_index, want.index));
            end
        end
    end

    // watchdog: too long without any handshake on any channel ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        // every input known from time zero, reset held low
        aresetn             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = mts_pkg::REG_TIMER_CLOCK_HZ;
        cfg_data            = '0;
        s_valid             = 1'b0;
        s_cmd               = mts_pkg::CMD_TICK;
        s_now_time          = '0;
        s_entry_index       = '0;
        s_entry_freq        = '0;
        s_entry_length_code = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_random_songs();
        test_output_backpressure();
        test_random_noise();

        // let the last responses in, then watch a while for strays
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests and %0d responses over %0d register settings",
                 request_count, response_count, reg_phases);
        $display("the model sounded %0d notes and reached %0d song ends; %0d mismatches",
                 notes_played, song_ends, mismatch_count);
        if (mismatch_count == 0 && predicted_status_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
